>>> rtl/mcs_pkg.sv
// ----------------------------------------------------------------------------
// mcs_pkg
// Types and constants shared by the migration candidate selector files.
// ----------------------------------------------------------------------------
package mcs_pkg;

    localparam int UTIL_W     = 17;   // Q1.16 utilization
    localparam int FRAC_W     = 16;   // fraction bits of the gap share
    localparam int ID_W       = 8;
    localparam int FLIGHT_W   = 8;
    localparam int GAP_FRAC_W = 16;   // min_gap_fraction is Q0.16
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    // item kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_CAND  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_CHOSEN = 2'd0;
    localparam logic [1:0] STATUS_NONE   = 2'd1;
    localparam logic [1:0] STATUS_LIMIT  = 2'd2;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_MIN_GAP   = 2'd0;
    localparam logic [1:0] REG_MAX_FLT   = 2'd1;
    localparam logic [1:0] REG_FIT_MODE  = 2'd2;

    // fit modes
    localparam logic FIT_BEST      = 1'b0;
    localparam logic FIT_NEXT_BEST = 1'b1;

    localparam logic [GAP_FRAC_W-1:0] MIN_GAP_RST  = 16'd6554;
    localparam logic [FLIGHT_W-1:0]   MAX_FLT_RST  = 8'd1;
    localparam logic                  FIT_MODE_RST = FIT_NEXT_BEST;

    typedef struct packed {
        logic [1:0]          kind;
        logic [UTIL_W-1:0]   node_util;
        logic [UTIL_W-1:0]   partner_util;
        logic [FLIGHT_W-1:0] in_flight;
        logic [ID_W-1:0]     object_id;
        logic [UTIL_W-1:0]   object_util;
        logic                is_stdout;
        logic                incomplete;
    } t_in_item;

    typedef struct packed {
        logic [1:0]      status;
        logic [ID_W-1:0] chosen_id;
    } t_out_item;

    typedef struct packed {
        logic [GAP_FRAC_W-1:0] min_gap_fraction;
        logic [FLIGHT_W-1:0]   max_in_flight;
        logic                  fit_mode;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [UTIL_W-1:0] util;
    } t_entry;

endpackage

>>> rtl/mcs_cfg_regs.sv
// ----------------------------------------------------------------------------
// mcs_cfg_regs
// APB register file: min_gap_fraction, max_in_flight and fit_mode.
// ----------------------------------------------------------------------------
module mcs_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mcs_pkg::PADDR_W-1:0]  paddr,
    input  logic [mcs_pkg::PDATA_W-1:0]  pwdata,
    output logic [mcs_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output mcs_pkg::t_cfg                o_cfg
);

    mcs_pkg::t_cfg r_cfg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_gap_fraction <= mcs_pkg::MIN_GAP_RST;
            r_cfg.max_in_flight    <= mcs_pkg::MAX_FLT_RST;
            r_cfg.fit_mode         <= mcs_pkg::FIT_MODE_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                mcs_pkg::REG_MIN_GAP:  begin
                    r_cfg.min_gap_fraction <= pwdata[mcs_pkg::GAP_FRAC_W-1:0];
                end
                mcs_pkg::REG_MAX_FLT:  begin
                    r_cfg.max_in_flight <= pwdata[mcs_pkg::FLIGHT_W-1:0];
                end
                mcs_pkg::REG_FIT_MODE: begin
                    r_cfg.fit_mode <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr[3:2])
            mcs_pkg::REG_MIN_GAP:  prdata = 32'(r_cfg.min_gap_fraction);
            mcs_pkg::REG_MAX_FLT:  prdata = 32'(r_cfg.max_in_flight);
            mcs_pkg::REG_FIT_MODE: prdata = 32'(r_cfg.fit_mode);
            default:               prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/migration_candidate_selector.sv
// ----------------------------------------------------------------------------
// migration_candidate_selector
// Scans candidate objects of a round and picks the one to migrate.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; each item updates the round state while it
// sits in the input register.
// Result: o_out_valid rises as the end-of-round item leaves the input register and
// its result is registered, unless an earlier result waits in the output register.
// Only an end item waits in the input register for that output register.
// Reset: synchronous, active low; clears round state, no pick, registers
// return to their reset values.
module migration_candidate_selector (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  mcs_pkg::t_in_item            i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output mcs_pkg::t_out_item           o_out_item,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mcs_pkg::PADDR_W-1:0]  paddr,
    input  logic [mcs_pkg::PDATA_W-1:0]  pwdata,
    output logic [mcs_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int UW = mcs_pkg::UTIL_W;
    localparam int PW = mcs_pkg::GAP_FRAC_W + UW;   // threshold product width
    localparam logic [PW:0] ROUND_UP = (PW+1)'((1 << mcs_pkg::GAP_FRAC_W) - 1);

    mcs_pkg::t_cfg      cfg;

    logic               r_s1_valid;
    mcs_pkg::t_in_item  r_s1_item;
    logic               r_out_valid;
    mcs_pkg::t_out_item r_out;

    // round state
    logic [UW-1:0]      r_gap;
    logic [UW-1:0]      r_own_util;
    logic               r_limit_hit;
    logic [UW-1:0]      r_thr;
    logic [UW-1:0]      r_best_gap;
    mcs_pkg::t_entry    r_pick;
    mcs_pkg::t_entry    r_top;
    mcs_pkg::t_entry    r_second;

    logic               s1_is_end;
    logic               s1_go;

    logic [UW-1:0]      start_gap;
    logic [PW-1:0]      thr_prod;
    logic [PW:0]        thr_sum;

    logic               cand_ok;
    logic [UW:0]        two_u;
    logic [UW:0]        gap_ext;
    logic [UW:0]        pred;
    logic               closer;
    logic               above_top;
    logic               above_second;

    mcs_pkg::t_entry    res;
    mcs_pkg::t_out_item n_out;

    mcs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // handshake
    assign s1_is_end  = (r_s1_item.kind == mcs_pkg::KIND_END);
    assign s1_go      = r_s1_valid && (!s1_is_end || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_go;

    // round start: gap and ceil(min_gap_fraction * gap / 2^16)
    always_comb begin
        if (r_s1_item.node_util > r_s1_item.partner_util) begin
            start_gap = r_s1_item.node_util - r_s1_item.partner_util;
        end else begin
            start_gap = '0;
        end
        thr_prod = PW'(cfg.min_gap_fraction) * PW'(start_gap);
        thr_sum  = (PW+1)'(thr_prod) + ROUND_UP;
    end

    // candidate: distance |gap - 2u| and ranking
    always_comb begin
        cand_ok = !r_s1_item.is_stdout && !r_s1_item.incomplete
                  && (r_s1_item.object_util >= r_thr);
        two_u   = {r_s1_item.object_util, 1'b0};
        gap_ext = {1'b0, r_gap};
        if (gap_ext >= two_u) begin
            pred = gap_ext - two_u;
        end else begin
            pred = two_u - gap_ext;
        end
        closer       = pred < {1'b0, r_best_gap};
        above_top    = !r_top.valid || (r_s1_item.object_util > r_top.util);
        above_second = !r_second.valid || (r_s1_item.object_util > r_second.util);
    end

    // end of round result
    always_comb begin
        res = r_pick;
        if (cfg.fit_mode == mcs_pkg::FIT_BEST) begin
            if (r_pick.valid && (r_pick.util >= r_own_util)) begin
                res.valid = 1'b0;
            end
        end else if (r_pick.valid && r_top.valid && (r_pick.id == r_top.id)
                     && (r_pick.util == r_top.util)) begin
            res = r_second;
        end
        if (r_limit_hit) begin
            n_out.status    = mcs_pkg::STATUS_LIMIT;
            n_out.chosen_id = '0;
        end else if (res.valid) begin
            n_out.status    = mcs_pkg::STATUS_CHOSEN;
            n_out.chosen_id = res.id;
        end else begin
            n_out.status    = mcs_pkg::STATUS_NONE;
            n_out.chosen_id = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && s1_is_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_is_end) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap       <= '0;
            r_own_util  <= '0;
            r_limit_hit <= 1'b0;
            r_thr       <= '0;
            r_best_gap  <= '0;
            r_pick      <= '0;
            r_top       <= '0;
            r_second    <= '0;
        end else if (s1_go) begin
            case (r_s1_item.kind)
                mcs_pkg::KIND_START: begin
                    r_gap       <= start_gap;
                    r_own_util  <= r_s1_item.node_util;
                    r_limit_hit <= r_s1_item.in_flight >= cfg.max_in_flight;
                    r_thr       <= thr_sum[PW-1:mcs_pkg::GAP_FRAC_W];
                    r_best_gap  <= start_gap;
                    r_pick      <= '0;
                    r_top       <= '0;
                    r_second    <= '0;
                end
                mcs_pkg::KIND_CAND: begin
                    if (cand_ok) begin
                        if (above_top) begin
                            r_second   <= r_top;
                            r_top      <= {1'b1, r_s1_item.object_id,
                                           r_s1_item.object_util};
                        end else if (above_second) begin
                            r_second   <= {1'b1, r_s1_item.object_id,
                                           r_s1_item.object_util};
                        end
                        if (closer) begin
                            r_best_gap <= pred[UW-1:0];
                            r_pick     <= {1'b1, r_s1_item.object_id,
                                           r_s1_item.object_util};
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // a result only ever appears after an end item left the input register
    a_out_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid && s1_is_end))
        else $error("result without end of round item");

    a_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status != mcs_pkg::STATUS_CHOSEN))
        |-> (r_out.chosen_id == '0))
        else $error("nonzero id without a pick");

    a_rank_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second.valid |-> (r_top.valid && (r_second.util <= r_top.util)))
        else $error("second entry ranks above top entry");

    a_best_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_gap <= r_gap)
        else $error("best distance above round gap");

endmodule
